// File: rtl/wtw_pkg.sv
// ----------------------------------------------------------------------------
// Write trace window checker package
// Beat types, record and command types, and status codes shared by the
// front end, the command queue, the window engine and the checker.
// ----------------------------------------------------------------------------
package wtw_pkg;

    // Status codes returned with every result beat.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISSED   = 2'd1;
    localparam logic [1:0] STATUS_NOMATCH  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // Depth of the command queue between the front end and the window engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input beat as it arrives on the port.
    typedef struct packed {
        logic        action;
        logic [1:0]  entry_kind;
        logic [63:0] dest_addr;
        logic [63:0] write_value;
        logic [30:0] insn_count;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] fill_level;
    } t_out_beat;

    // One expected write record as held in the window.
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] dest;
        logic [63:0] value;
        logic [30:0] count;
    } t_record;

    // Operation decoded by the front end.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_CHECK = 1'b1
    } t_op;

    // Command passed through the queue to the window engine.
    typedef struct packed {
        t_op     op;
        t_record rec;
    } t_cmd;

endpackage

// File: rtl/wtw_front.sv
// ----------------------------------------------------------------------------
// Write trace window checker front end
// Accepts input beats, decodes them into load or check commands and holds
// each one in a register until the command queue takes it.
// ----------------------------------------------------------------------------
module wtw_front
    import wtw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_beat i_in_data,
    output logic     o_push_valid,
    output t_cmd     o_push_cmd,
    input  logic     i_push_ready
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // The holding register frees up in the same cycle that the queue takes it.
    assign o_in_stall = r_valid && !i_push_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // Decode the beat into a command.
    always_comb begin
        n_valid = r_valid && !i_push_ready;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid         = 1'b1;
            n_cmd.op        = i_in_data.action ? OP_CHECK : OP_LOAD;
            n_cmd.rec.kind  = i_in_data.entry_kind;
            n_cmd.rec.dest  = i_in_data.dest_addr;
            n_cmd.rec.value = i_in_data.write_value;
            n_cmd.rec.count = i_in_data.insn_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

// File: rtl/wtw_queue.sv
// ----------------------------------------------------------------------------
// Write trace window checker command queue
// A short first-in first-out queue that decouples the front end from the
// window engine so that each side can stall on its own.
// ----------------------------------------------------------------------------
module wtw_queue
    import wtw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: rtl/wtw_engine.sv
// ----------------------------------------------------------------------------
// Write trace window checker engine
// Holds the window of expected records, appends on load commands and scans
// oldest first on check commands, one record per cycle, then closes the gap
// left by a matched record. Results go out through a registered beat.
// ----------------------------------------------------------------------------
module wtw_engine
    import wtw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pop_valid,
    input  t_cmd      i_pop_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int OCC_W = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SCAN = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic [OCC_W-1:0] r_idx;
    logic [OCC_W-1:0] n_idx;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    t_record          r_win [WINDOW_DEPTH];
    t_record          n_win [WINDOW_DEPTH];
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_beat        r_out_data;
    t_out_beat        n_out_data;
    t_record          cur_rec;
    logic             slot_free;

    // The record under the scan pointer; only read while the pointer is below
    // the occupancy, so the part-select always lands on a stored entry.
    assign cur_rec   = r_win[r_idx[IDX_W-1:0]];
    assign slot_free = !r_out_valid || !i_out_stall;

    // Sequencer for one command at a time.
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_win       = r_win;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // Take a command only once the result slot is sure to be free.
                if (i_pop_valid && slot_free) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_pop_cmd;
                    n_idx   = '0;
                    n_state = (i_pop_cmd.op == OP_CHECK) ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
                if (r_occ < OCC_W'(WINDOW_DEPTH)) begin
                    n_win[r_occ[IDX_W-1:0]] = r_cmd.rec;
                    n_occ                   = r_occ + 1'b1;
                    n_out_data.status       = STATUS_OK;
                    n_out_data.fill_level   = 3'(r_occ + 1'b1);
                end else begin
                    n_out_data.status     = STATUS_OVERFLOW;
                    n_out_data.fill_level = 3'(r_occ);
                end
            end
            ST_SCAN: begin
                if (r_idx >= r_occ) begin
                    // Ran past the youngest record without a match.
                    n_out_valid           = 1'b1;
                    n_out_data.status     = STATUS_NOMATCH;
                    n_out_data.fill_level = 3'(r_occ);
                    n_state               = ST_IDLE;
                end else if (cur_rec.count < r_cmd.rec.count) begin
                    // An older expected write was never observed.
                    n_out_valid           = 1'b1;
                    n_out_data.status     = STATUS_MISSED;
                    n_out_data.fill_level = 3'(r_occ);
                    n_state               = ST_IDLE;
                end else if (cur_rec == r_cmd.rec) begin
                    // Remove the match and move the younger records up.
                    for (int j = 0; j < WINDOW_DEPTH - 1; j++) begin
                        if (OCC_W'(j) >= r_idx) begin
                            n_win[j] = r_win[j + 1];
                        end
                    end
                    n_occ                 = r_occ - 1'b1;
                    n_out_valid           = 1'b1;
                    n_out_data.status     = STATUS_OK;
                    n_out_data.fill_level = 3'(r_occ - 1'b1);
                    n_state               = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: window records, current command and result beat.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_win      <= n_win;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/write_trace_window_checker.sv
// ----------------------------------------------------------------------------
// Write trace window checker
// Keeps a window of expected write records, appends them on load beats and
// checks observed writes against them oldest first, reporting one status beat
// per input beat.
// ----------------------------------------------------------------------------
// Path: an input beat is registered in the front end, passes through the queue
//   and the engine state, and its result leaves through the result register;
//   a check result also waits while the engine scans one record per cycle.
// The engine takes a new command only after the last one has finished.
// Reset (synchronous, active low) empties the window and the queue; the
//   record store itself is not cleared.
module write_trace_window_checker
    import wtw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic push_valid;
    t_cmd push_cmd;
    logic push_ready;
    logic pop_valid;
    t_cmd pop_cmd;
    logic pop;

    // Accept and decode.
    wtw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    // Decoupling queue.
    wtw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    // Window engine.
    wtw_engine #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/wtw_checker.sv
// ----------------------------------------------------------------------------
// Write trace window checker assertions
// Port-level checks on the result channel, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wtw_checker
    import wtw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_stall,
    input logic      o_out_valid,
    input t_out_beat o_out_data
);

    // A stalled result beat stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_out_valid && i_out_stall) |-> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // For window depths below 8, the reported fill level never exceeds the window depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (WINDOW_DEPTH >= 8) ||
            (o_out_data.fill_level <= 3'(WINDOW_DEPTH)))
        else $error("fill level beyond window depth");

    // An overflow is only reported with a full window.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == STATUS_OVERFLOW) |->
            o_out_data.fill_level == 3'(WINDOW_DEPTH))
        else $error("overflow reported with window not full");

endmodule

bind write_trace_window_checker wtw_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_wtw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data)
);
